>>> hdl/char_lcd_nibble_write_sequencer_macros.svh
// Assertion macros for the character LCD nibble write sequencer.
// Expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef CHAR_LCD_NIBBLE_WRITE_SEQUENCER_MACROS_SVH
`define CHAR_LCD_NIBBLE_WRITE_SEQUENCER_MACROS_SVH

// Condition that must hold at every clock edge out of reset
`define LCD_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Consequence that must hold in the cycle after the antecedent
`define LCD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/lcd_seq_pkg.sv
// Types and constants for the character LCD nibble write sequencer.
// No dependencies.
package lcd_seq_pkg;

    // Request kinds carried on the input tuser
    typedef enum logic [1:0] {
        MODE_TICK = 2'd0,
        MODE_INIT = 2'd1,
        MODE_CMD  = 2'd2,
        MODE_DATA = 2'd3
    } mode_t;

    // Sequencer phases
    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_POWER = 3'd1,
        PH_SETUP = 3'd2,
        PH_PULSE = 3'd3,
        PH_HOLD  = 3'd4,
        PH_POST  = 3'd5
    } phase_t;

    // Init sequence steps
    localparam logic [3:0] INIT_NONE     = 4'd0;
    localparam logic [3:0] INIT_WAKE_1   = 4'd1;
    localparam logic [3:0] INIT_WAKE_2   = 4'd2;
    localparam logic [3:0] INIT_WAKE_3   = 4'd3;
    localparam logic [3:0] INIT_4BIT     = 4'd4;
    localparam logic [3:0] INIT_FUNC_SET = 4'd5;
    localparam logic [3:0] INIT_DISP_ON  = 4'd6;
    localparam logic [3:0] INIT_CLEAR    = 4'd7;
    localparam logic [3:0] INIT_ENTRY    = 4'd8;

    // Nibbles and command bytes
    localparam logic [3:0] NIB_WAKE       = 4'h3;
    localparam logic [3:0] NIB_4BIT       = 4'h2;
    localparam logic [7:0] CMD_FUNC_SET   = 8'h28;
    localparam logic [7:0] CMD_DISP_ON    = 8'h0C;
    localparam logic [7:0] CMD_CLEAR      = 8'h01;
    localparam logic [7:0] CMD_HOME       = 8'h02;
    localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;

    // Waits after the wake-up nibbles, in microseconds
    localparam logic [15:0] WAKE_1_WAIT_US = 16'd5000;
    localparam logic [15:0] WAKE_N_WAIT_US = 16'd1000;

    // Full sequencer state
    typedef struct packed {
        phase_t      phase;
        logic [15:0] wait_count;
        logic [7:0]  held_byte;
        logic        nibble_select;
        logic [3:0]  init_step;
        logic        rs_level;
        logic        enable_level;
        logic [3:0]  nibble_level;
    } lcd_state_t;

    // One result item
    typedef struct packed {
        logic       rs_pin;
        logic       enable_pin;
        logic [3:0] data_nibble;
        logic       busy_res;
        logic       accepted;
    } lcd_result_t;

endpackage

>>> hdl/char_lcd_nibble_write_sequencer.sv
// Character LCD 4-bit write sequencer: tick/request stream in, pin levels out.
// Depends on lcd_seq_pkg and char_lcd_nibble_write_sequencer_macros.svh.
//
//  channel | dir | tdata                | tuser
//  --------+-----+----------------------+---------------
//  s_*     | in  | byte_value [7:0]     | mode [1:0]
//  m_*     | out | enable, nibble, busy,| rs_pin [0]
//          |     | accepted, pad        |
//
// One request per cycle sustained unless m_tready stalls; a request passes the
// input register, then the result register. The state update for an item is one
// pass of logic between them, so back-to-back items see each other's effect.
// Reset clears the sequencer state and both valid flags.
// A stall on m_tready holds the result; one further request waits in the
// input register before s_tready drops.
`include "char_lcd_nibble_write_sequencer_macros.svh"

module char_lcd_nibble_write_sequencer #(
    parameter int ENABLE_HOLD_US   = 100,
    parameter int CLEAR_WAIT_US    = 2000,
    parameter int POWER_ON_WAIT_US = 50000
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] byte_value
    input  logic [1:0] s_tuser,   // [1:0] mode
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [0] enable_pin, [4:1] data_nibble, [5] busy_res,
                                  // [6] accepted, [7] zero
    output logic       m_tuser    // [0] rs_pin
);
    import lcd_seq_pkg::*;

    logic        in_valid_reg;
    mode_t       in_mode_reg;
    logic [7:0]  in_byte_reg;
    logic        out_valid_reg;
    lcd_result_t out_reg;
    lcd_state_t  state_reg;
    lcd_state_t  state_next;
    logic        acc_next;
    logic        consume;

    // ---- sequencer helpers ----
    function automatic lcd_state_t start_nibble(lcd_state_t s, logic [3:0] nib);
        lcd_state_t r;
        r = s;
        r.nibble_level = nib;
        r.enable_level = 1'b0;
        r.phase        = PH_SETUP;
        r.wait_count   = 16'd1;
        return r;
    endfunction

    function automatic lcd_state_t start_byte(lcd_state_t s, logic [7:0] b);
        lcd_state_t r;
        r = s;
        r.held_byte     = b;
        r.nibble_select = 1'b0;
        return start_nibble(r, b[7:4]);
    endfunction

    function automatic logic [7:0] init_cmd(logic [3:0] step);
        logic [7:0] c;
        case (step)
            INIT_FUNC_SET: c = CMD_FUNC_SET;
            INIT_DISP_ON:  c = CMD_DISP_ON;
            INIT_CLEAR:    c = CMD_CLEAR;
            default:       c = CMD_ENTRY_MODE;
        endcase
        return c;
    endfunction

    function automatic lcd_state_t launch_init(lcd_state_t s);
        lcd_state_t r;
        r = s;
        r.rs_level = 1'b0;
        if (s.init_step >= INIT_WAKE_1 && s.init_step <= INIT_WAKE_3)
        begin
            r.nibble_select = 1'b1;
            r = start_nibble(r, NIB_WAKE);
        end
        else if (s.init_step == INIT_4BIT)
        begin
            r.nibble_select = 1'b1;
            r = start_nibble(r, NIB_4BIT);
        end
        else
        begin
            r = start_byte(r, init_cmd(s.init_step));
        end
        return r;
    endfunction

    function automatic lcd_state_t transfer_done(lcd_state_t s);
        lcd_state_t r;
        r = s;
        if (s.init_step != INIT_NONE && s.init_step < INIT_ENTRY)
        begin
            r.init_step = s.init_step + 4'd1;
            r = launch_init(r);
        end
        else
        begin
            r.init_step  = INIT_NONE;
            r.phase      = PH_IDLE;
            r.wait_count = 16'd0;
        end
        return r;
    endfunction

    function automatic lcd_state_t after_hold(lcd_state_t s);
        lcd_state_t  r;
        logic [15:0] post;
        r    = s;
        post = 16'd0;
        if (!s.nibble_select)
        begin
            // high nibble done, low nibble next
            r.nibble_select = 1'b1;
            r = start_nibble(r, s.held_byte[3:0]);
        end
        else
        begin
            r.nibble_select = 1'b0;
            case (s.init_step)
                INIT_WAKE_1: post = WAKE_1_WAIT_US;
                INIT_WAKE_2: post = WAKE_N_WAIT_US;
                INIT_WAKE_3: post = WAKE_N_WAIT_US;
                INIT_4BIT:   post = 16'd0;
                default:
                begin
                    if (!s.rs_level && (s.held_byte == CMD_CLEAR || s.held_byte == CMD_HOME))
                        post = 16'(CLEAR_WAIT_US);
                end
            endcase
            if (post != 16'd0)
            begin
                r.phase      = PH_POST;
                r.wait_count = post;
            end
            else
            begin
                r = transfer_done(r);
            end
        end
        return r;
    endfunction

    function automatic lcd_state_t tick_step(lcd_state_t s);
        lcd_state_t r;
        r = s;
        if (s.phase != PH_IDLE)
        begin
            if (s.wait_count > 16'd1)
            begin
                r.wait_count = s.wait_count - 16'd1;
            end
            else
            begin
                case (s.phase)
                    PH_POWER:
                    begin
                        r.init_step = INIT_WAKE_1;
                        r = launch_init(r);
                    end
                    PH_SETUP:
                    begin
                        r.enable_level = 1'b1;
                        r.phase        = PH_PULSE;
                        r.wait_count   = 16'd1;
                    end
                    PH_PULSE:
                    begin
                        r.enable_level = 1'b0;
                        r.phase        = PH_HOLD;
                        r.wait_count   = 16'(ENABLE_HOLD_US);
                        if (r.wait_count == 16'd0)
                            r = after_hold(r);
                    end
                    PH_HOLD:  r = after_hold(r);
                    PH_POST:  r = transfer_done(r);
                    default:
                    begin
                        r.phase      = PH_IDLE;
                        r.wait_count = 16'd0;
                    end
                endcase
            end
        end
        return r;
    endfunction

    // ---- handshake ----
    assign consume  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || consume;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_mode_reg <= mode_t'(s_tuser);
            in_byte_reg <= s_tdata;
        end
    end

    // Next state for the registered request
    always_comb
    begin
        state_next = state_reg;
        acc_next   = 1'b0;
        case (in_mode_reg)
            MODE_TICK: state_next = tick_step(state_reg);
            MODE_INIT:
            begin
                if (state_reg.phase == PH_IDLE)
                begin
                    acc_next                 = 1'b1;
                    state_next.rs_level      = 1'b0;
                    state_next.enable_level  = 1'b0;
                    state_next.nibble_select = 1'b0;
                    state_next.init_step     = INIT_NONE;
                    state_next.phase         = PH_POWER;
                    state_next.wait_count    = 16'(POWER_ON_WAIT_US);
                end
            end
            default:
            begin
                if (state_reg.phase == PH_IDLE)
                begin
                    acc_next             = 1'b1;
                    state_next.init_step = INIT_NONE;
                    state_next.rs_level  = (in_mode_reg == MODE_DATA);
                    state_next           = start_byte(state_next, in_byte_reg);
                end
            end
        endcase
    end

    // Sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase         <= PH_IDLE;
            state_reg.wait_count    <= 16'd0;
            state_reg.held_byte     <= 8'd0;
            state_reg.nibble_select <= 1'b0;
            state_reg.init_step     <= INIT_NONE;
            state_reg.rs_level      <= 1'b0;
            state_reg.enable_level  <= 1'b0;
            state_reg.nibble_level  <= 4'd0;
        end
        else if (consume)
        begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (consume)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (consume)
        begin
            out_reg.rs_pin      <= state_next.rs_level;
            out_reg.enable_pin  <= state_next.enable_level;
            out_reg.data_nibble <= state_next.nibble_level;
            out_reg.busy_res    <= (state_next.phase != PH_IDLE);
            out_reg.accepted    <= acc_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.rs_pin;
    assign m_tdata  = {1'b0, out_reg.accepted, out_reg.busy_res,
                       out_reg.data_nibble, out_reg.enable_pin};

    // ---- assertions ----
    `LCD_ASSERT_ALWAYS(a_enable_only_in_pulse,
        !state_reg.enable_level || state_reg.phase == PH_PULSE,
        "enable high outside the pulse phase")
    `LCD_ASSERT_ALWAYS(a_busy_has_count,
        state_reg.phase == PH_IDLE || state_reg.wait_count != 16'd0,
        "active phase with an empty countdown")
    `LCD_ASSERT_ALWAYS(a_result_tracks_state,
        !out_valid_reg || (out_reg.busy_res == (state_reg.phase != PH_IDLE)),
        "held result disagrees with sequencer state")
    `LCD_ASSERT_NEXT(a_busy_refuses,
        consume && state_reg.phase != PH_IDLE && in_mode_reg != MODE_TICK,
        !out_reg.accepted && $stable(state_reg),
        "request taken while busy")

endmodule

>>> tb/lcd_seq_checker.sv
`timescale 1ns / 100ps
// Checker for the character LCD nibble write sequencer: predicts pin levels per request.
// Watches both stream channels of the block; depends on lcd_seq_pkg.

module lcd_seq_checker
    import lcd_seq_pkg::*;
#(
    parameter int HOLD_US  = 100,
    parameter int CLEAR_US = 2000,
    parameter int POWER_US = 50000
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] byte_value
    input  logic [1:0] s_tuser,   // [1:0] mode
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,   // [0] enable_pin, [4:1] data_nibble, [5] busy_res,
                                  // [6] accepted, [7] zero
    input  logic       m_tuser,   // [0] rs_pin
    output int         mismatches,
    output int         pending
);

    // Predicted sequencer state
    phase_t      seq_phase;
    logic [15:0] us_left;
    logic [7:0]  byte_q;
    logic        low_next;
    logic [3:0]  init_pos;
    logic        rs_q;
    logic        en_q;
    logic [3:0]  nib_q;

    // Pin levels still to come out, oldest first
    lcd_result_t pins_due[$];
    int          err_count;
    lcd_result_t want_pins;
    lcd_result_t got_pins;

    // Put a nibble on the data lines and start its setup time
    function automatic void drive_nibble(input logic [3:0] nib);
        nib_q     = nib;
        en_q      = 1'b0;
        seq_phase = PH_SETUP;
        us_left   = 16'd1;
    endfunction

    function automatic void drive_byte(input logic [7:0] b);
        byte_q   = b;
        low_next = 1'b0;
        drive_nibble(b[7:4]);
    endfunction

    // Kick off the transfer belonging to the current init step
    function automatic void start_init_step();
        rs_q = 1'b0;
        if (init_pos >= INIT_WAKE_1 && init_pos <= INIT_WAKE_3)
        begin
            low_next = 1'b1;
            drive_nibble(NIB_WAKE);
        end
        else if (init_pos == INIT_4BIT)
        begin
            low_next = 1'b1;
            drive_nibble(NIB_4BIT);
        end
        else
        begin
            case (init_pos)
                INIT_DISP_ON: drive_byte(CMD_DISP_ON);
                INIT_CLEAR:   drive_byte(CMD_CLEAR);
                INIT_ENTRY:   drive_byte(CMD_ENTRY_MODE);
                default:      drive_byte(CMD_FUNC_SET);
            endcase
        end
    endfunction

    // A whole transfer (and its wait) is over: next init step or idle
    function automatic void finish_transfer();
        if (init_pos != INIT_NONE && init_pos < INIT_ENTRY)
        begin
            init_pos = init_pos + 4'd1;
            start_init_step();
        end
        else
        begin
            init_pos  = INIT_NONE;
            seq_phase = PH_IDLE;
            us_left   = '0;
        end
    endfunction

    // Hold time after the enable strobe has run out
    function automatic void end_of_hold();
        logic [15:0] post_us;
        post_us = '0;
        if (!low_next)
        begin
            low_next = 1'b1;
            drive_nibble(byte_q[3:0]);
        end
        else
        begin
            low_next = 1'b0;
            if (init_pos == INIT_WAKE_1)
                post_us = WAKE_1_WAIT_US;
            else if (init_pos == INIT_WAKE_2 || init_pos == INIT_WAKE_3)
                post_us = WAKE_N_WAIT_US;
            else if (init_pos == INIT_4BIT)
                post_us = '0;
            else if (!rs_q && (byte_q == CMD_CLEAR || byte_q == CMD_HOME))
                post_us = 16'(CLEAR_US);
            if (post_us != '0)
            begin
                seq_phase = PH_POST;
                us_left   = post_us;
            end
            else
                finish_transfer();
        end
    endfunction

    // One microsecond tick
    function automatic void advance_one_us();
        if (seq_phase == PH_IDLE)
            return;
        if (us_left > 16'd1)
        begin
            us_left = us_left - 16'd1;
            return;
        end
        case (seq_phase)
            PH_POWER:
            begin
                init_pos = INIT_WAKE_1;
                start_init_step();
            end
            PH_SETUP:
            begin
                en_q      = 1'b1;
                seq_phase = PH_PULSE;
                us_left   = 16'd1;
            end
            PH_PULSE:
            begin
                en_q      = 1'b0;
                seq_phase = PH_HOLD;
                us_left   = 16'(HOLD_US);
                if (us_left == '0)
                    end_of_hold();
            end
            PH_HOLD: end_of_hold();
            PH_POST: finish_transfer();
            default:
            begin
                seq_phase = PH_IDLE;
                us_left   = '0;
            end
        endcase
    endfunction

    // Apply one request to the predicted state and return the pin levels after it
    function automatic lcd_result_t predict_pins(input mode_t m, input logic [7:0] b);
        lcd_result_t r;
        logic        took;
        took = 1'b0;
        if (m == MODE_TICK)
            advance_one_us();
        else if (seq_phase == PH_IDLE)
        begin
            took     = 1'b1;
            init_pos = INIT_NONE;
            if (m == MODE_INIT)
            begin
                rs_q      = 1'b0;
                en_q      = 1'b0;
                low_next  = 1'b0;
                seq_phase = PH_POWER;
                us_left   = 16'(POWER_US);
            end
            else
            begin
                rs_q = (m == MODE_DATA);
                drive_byte(b);
            end
        end
        r.rs_pin      = rs_q;
        r.enable_pin  = en_q;
        r.data_nibble = nib_q;
        r.busy_res    = (seq_phase != PH_IDLE);
        r.accepted    = took;
        return r;
    endfunction

    function automatic void check_pins(input lcd_result_t want, input lcd_result_t got);
        if (want.rs_pin !== got.rs_pin || want.enable_pin !== got.enable_pin ||
            want.data_nibble !== got.data_nibble || want.busy_res !== got.busy_res ||
            want.accepted !== got.accepted)
        begin
            err_count++;
            if (err_count <= 10)
                $display("%0t: pin mismatch, expected rs %0b en %0b nib %h busy %0b acc %0b, got rs %0b en %0b nib %h busy %0b acc %0b",
                         $time, want.rs_pin, want.enable_pin, want.data_nibble,
                         want.busy_res, want.accepted, got.rs_pin, got.enable_pin,
                         got.data_nibble, got.busy_res, got.accepted);
        end
    endfunction

    // Compare results as they leave, predict for requests as they enter
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_phase  = PH_IDLE;
            us_left    = '0;
            byte_q     = '0;
            low_next   = 1'b0;
            init_pos   = INIT_NONE;
            rs_q       = 1'b0;
            en_q       = 1'b0;
            nib_q      = '0;
            err_count  = 0;
            pins_due.delete();
            mismatches <= 0;
            pending    <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got_pins.rs_pin      = m_tuser;
                got_pins.enable_pin  = m_tdata[0];
                got_pins.data_nibble = m_tdata[4:1];
                got_pins.busy_res    = m_tdata[5];
                got_pins.accepted    = m_tdata[6];
                if (pins_due.size() == 0)
                begin
                    err_count++;
                    if (err_count <= 10)
                        $display("%0t: result with nothing expected, got tdata %h tuser %0b",
                                 $time, m_tdata, m_tuser);
                end
                else
                begin
                    want_pins = pins_due.pop_front();
                    check_pins(want_pins, got_pins);
                end
            end
            if (s_tvalid && s_tready)
                pins_due.push_back(predict_pins(mode_t'(s_tuser), s_tdata));
            mismatches <= err_count;
            pending    <= pins_due.size();
        end
    end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// Top of the LCD nibble write sequencer testbench: clock, reset, request stimulus, verdict.
// Depends on lcd_seq_pkg, char_lcd_nibble_write_sequencer and lcd_seq_checker.

module tb_top;
    import lcd_seq_pkg::*;

    localparam int HOLD_US      = 100;
    localparam int CLEAR_US     = 2000;
    localparam int POWER_US     = 50000;
    localparam int RANDOM_ITEMS = 250;
    localparam int TAIL_ITEMS   = 40;
    localparam int LONG_HOLD    = 400;
    localparam int QUIET_LIMIT  = 4000;
    localparam int TAIL_CYCLES  = 10;

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;   // [7:0] byte_value
    logic [1:0] s_tuser;   // [1:0] mode
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;   // [0] enable_pin, [4:1] data_nibble, [5] busy_res,
                           // [6] accepted, [7] zero
    logic       m_tuser;   // [0] rs_pin

    int   mismatches;
    int   pending;
    int   quiet_cycles = 0;
    logic idling_on;
    logic hold_stretch;

    char_lcd_nibble_write_sequencer #(
        .ENABLE_HOLD_US   (HOLD_US),
        .CLEAR_WAIT_US    (CLEAR_US),
        .POWER_ON_WAIT_US (POWER_US)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    lcd_seq_checker #(
        .HOLD_US  (HOLD_US),
        .CLEAR_US (CLEAR_US),
        .POWER_US (POWER_US)
    ) i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .mismatches (mismatches),
        .pending    (pending)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Ticks a request keeps the block busy for
    function automatic int us_to_idle(input mode_t m, input logic [7:0] b);
        int nib_us;
        nib_us = 2 + HOLD_US;
        case (m)
            MODE_INIT:
                return POWER_US + 4 * nib_us + int'(WAKE_1_WAIT_US)
                       + 2 * int'(WAKE_N_WAIT_US) + 8 * nib_us + CLEAR_US;
            MODE_CMD:
                return 2 * nib_us + ((b == CMD_CLEAR || b == CMD_HOME) ? CLEAR_US : 0);
            MODE_DATA:
                return 2 * nib_us;
            default:
                return 0;
        endcase
    endfunction

    // Offer one request and hold it until taken; random gaps in front
    task automatic offer_request(input mode_t m, input logic [7:0] b);
        if (idling_on && $urandom_range(0, 39) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= m;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic run_ticks(input int n);
        repeat (n) offer_request(MODE_TICK, 8'($urandom_range(0, 255)));
    endtask

    // Stop sending until every predicted result has come out
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Result side: random stalls, plus one long hold-off on request
    initial
    begin : sink
        int stall_left;
        stall_left = 0;
        m_tready   = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_stretch)
            begin
                hold_stretch = 1'b0;
                stall_left   = LONG_HOLD;
            end
            else if (stall_left == 0 && idling_on && $urandom_range(0, 39) == 0)
                stall_left = $urandom_range(1, 18);
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Watchdog on cycles with no handshake on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
                if (quiet_cycles >= QUIET_LIMIT)
                begin
                    $display("Mismatches found");
                    $finish;
                end
            end
        end
    end

    initial
    begin : stimulus
        int          busy_left;
        mode_t       m;
        logic [7:0]  b;

        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = MODE_TICK;
        rst_n        = 1'b0;
        idling_on    = 1'b1;
        hold_stretch = 1'b0;
        busy_left    = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: ticks while idle do nothing
        offer_request(MODE_TICK, 8'h00);
        offer_request(MODE_TICK, 8'hFF);

        // Request on the very last busy tick is refused
        offer_request(MODE_CMD, 8'h00);
        run_ticks(us_to_idle(MODE_CMD, 8'h00) - 1);
        offer_request(MODE_DATA, 8'hA5);
        run_ticks(1);

        // Data byte that looks like clear gets no extra wait
        offer_request(MODE_DATA, CMD_CLEAR);
        run_ticks(us_to_idle(MODE_DATA, CMD_CLEAR));

        // Random mix of ticks and requests, taken or refused; one long hold-off
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == 60)
                hold_stretch = 1'b1;
            if ($urandom_range(0, 9) == 0)
            begin
                m = ($urandom_range(0, 1) == 0) ? MODE_DATA : MODE_CMD;
                b = 8'($urandom_range(0, 255));
                // keep the long clear wait out so that init can follow
                if (m == MODE_CMD && (b == CMD_CLEAR || b == CMD_HOME))
                    b = CMD_ENTRY_MODE;
                offer_request(m, b);
                if (busy_left == 0)
                    busy_left = us_to_idle(m, b);
            end
            else
            begin
                run_ticks(1);
                if (busy_left > 0)
                    busy_left--;
            end
        end
        run_ticks(busy_left);
        wait_for_drain();

        // Init keeps the last nibble on the lines; everything after it is refused
        idling_on = 1'b0;
        offer_request(MODE_INIT, 8'hFF);
        for (int i = 0; i < TAIL_ITEMS; i++)
        begin
            if ($urandom_range(0, 3) == 0)
                offer_request(mode_t'($urandom_range(1, 3)), 8'($urandom_range(0, 255)));
            else
                run_ticks(1);
        end

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> char_lcd_nibble_write_sequencer.f
+incdir+hdl
hdl/lcd_seq_pkg.sv
hdl/char_lcd_nibble_write_sequencer.sv
tb/lcd_seq_checker.sv
tb/tb_top.sv
